// File: sv/awcb_pkg.sv
// Package for the affine warp block: payload structs, register codes, frame geometry.
// Used by every module of the block; depends on nothing.
package awcb_pkg;

  localparam int FrameWidth  = 64;
  localparam int FrameHeight = 64;
  localparam int MaxBlur     = 20;
  localparam int XW = $clog2(FrameWidth);
  localparam int YW = $clog2(FrameHeight);
  localparam int AW = XW + YW;

  localparam logic [2:0] REG_COS   = 3'd0;
  localparam logic [2:0] REG_SIN   = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_SHX   = 3'd3;
  localparam logic [2:0] REG_SHY   = 3'd4;
  localparam logic [2:0] REG_BLUR  = 3'd5;
  localparam logic [2:0] REG_OPAC  = 3'd6;
  localparam logic [2:0] REG_BG    = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_border;
  } res_t;

  typedef struct packed {
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic [16:0]        inv_scale;
    logic signed [17:0] shake_x;
    logic signed [17:0] shake_y;
    logic [4:0]         cross_rad;
    logic [8:0]         opacity;
    logic [23:0]        back_rgb;
  } cfg_t;

  // opacity scaling with saturation
  function automatic logic [7:0] scale_alpha(input logic [7:0] a, input logic [8:0] op);
    logic [16:0] v;
    v = ({9'd0, a} * {8'd0, op}) >> 8;
    return (v > 17'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

// File: sv/awcb_regs.sv
// APB register file for the warp settings.
// Depends on awcb_pkg.
module awcb_regs import awcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_cos     <= 16'sd16384;
      cfg.rot_sin     <= '0;
      cfg.inv_scale   <= 17'd36409;
      cfg.shake_x     <= '0;
      cfg.shake_y     <= '0;
      cfg.cross_rad   <= '0;
      cfg.opacity     <= 9'd256;
      cfg.back_rgb    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_COS:   cfg.rot_cos     <= pwdata[15:0];
        REG_SIN:   cfg.rot_sin     <= pwdata[15:0];
        REG_SCALE: cfg.inv_scale   <= pwdata[16:0];
        REG_SHX:   cfg.shake_x     <= pwdata[17:0];
        REG_SHY:   cfg.shake_y     <= pwdata[17:0];
        REG_BLUR:  cfg.cross_rad   <= pwdata[4:0];
        REG_OPAC:  cfg.opacity     <= pwdata[8:0];
        default:   cfg.back_rgb    <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COS:   prdata = {16'd0, cfg.rot_cos};
      REG_SIN:   prdata = {16'd0, cfg.rot_sin};
      REG_SCALE: prdata = {15'd0, cfg.inv_scale};
      REG_SHX:   prdata = {14'd0, cfg.shake_x};
      REG_SHY:   prdata = {14'd0, cfg.shake_y};
      REG_BLUR:  prdata = {27'd0, cfg.cross_rad};
      REG_OPAC:  prdata = {23'd0, cfg.opacity};
      default:   prdata = {8'd0, cfg.back_rgb};
    endcase
  end
endmodule

// File: sv/awcb_div.sv
// Restoring divider: 14-bit sum by 6-bit sample count, one quotient bit a cycle.
// Depends on awcb_pkg.
module awcb_div import awcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [13:0] num,
  input  logic [5:0]  den,
  output logic        done,
  output logic [7:0]  quo
);
  logic [13:0] q;
  logic [6:0]  rem;
  logic [3:0]  cnt;
  logic        run;
  logic [7:0]  trial;

  assign trial = {rem, q[13]} - {2'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 4'd0;
      end else if (run) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd13) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= num;
      rem <= '0;
    end else if (run) begin
      if (!trial[7]) begin
        rem <= trial[6:0];
        q   <= {q[12:0], 1'b1};
      end else begin
        rem <= {rem[5:0], q[13]};
        q   <= {q[12:0], 1'b0};
      end
    end
  end
  // quotient fits in 8 bits: it is an average of bytes
  assign quo = q[7:0];
endmodule

// File: sv/awcb_core.sv
// Frame store and render sequencer: warp address pipeline, blur sample sweep, averaging.
// Depends on awcb_pkg and awcb_div.
module awcb_core import awcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  input  cfg_t cfg,
  output logic busy,
  output logic strobe,
  output res_t res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_SAMP = 4'd4, S_LAST = 4'd5, S_DIV = 4'd6, S_WAITD = 4'd7,
                         S_OUT = 4'd8;

  logic [31:0] mem [FrameWidth*FrameHeight];
  logic [31:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic        rd_en;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
    if (rd_en) rdata <= mem[raddr];
  end

  logic [3:0] state;
  req_t       rq;
  logic signed [24:0] px, py;
  logic signed [41:0] pxc, pys, pxs, pyc;
  logic signed [43:0] sx, sy;
  logic signed [12:0] bx, by;
  logic [4:0]  rad;
  logic [4:0]  rad_sat;
  logic signed [6:0] off;
  logic        phase;   // 0 horizontal sample, 1 vertical
  logic        pend;    // a read issued last cycle
  logic [13:0] sum [4];
  logic [5:0]  n;
  logic [1:0]  ch;
  logic        dgo, ddone;
  logic [7:0]  dq;
  logic [7:0]  avg [4];
  logic        border;

  assign busy = (state != S_IDLE);
  assign we   = start && !busy && !req.req_type;
  assign waddr = {req.pos_y[YW-1:0], req.pos_x[XW-1:0]};

  // source position in units of 2^-31 pixel
  assign sx = 44'(pxc) - 44'(pys) + (44'sd1 <<< 30) * FrameWidth
              + (44'(cfg.shake_x) <<< 23);
  assign sy = 44'(pxs) + 44'(pyc) + (44'sd1 <<< 30) * FrameHeight
              + (44'(cfg.shake_y) <<< 23);
  assign rad_sat = (cfg.cross_rad > 5'(MaxBlur)) ? 5'(MaxBlur) : cfg.cross_rad;

  // current sample coordinates
  logic signed [12:0] hx, vy;
  logic hv_ok, vv_ok;
  assign hx = bx + 13'(off);
  assign vy = by + 13'(off);
  assign hv_ok = (hx >= 0) && (hx < FrameWidth);
  assign vv_ok = (off != 0) && (vy >= 0) && (vy < FrameHeight);

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    if (state == S_SAMP) begin
      if (!phase) begin
        rd_en = hv_ok;
        raddr = {by[YW-1:0], hx[XW-1:0]};
      end else begin
        rd_en = vv_ok;
        raddr = {vy[YW-1:0], bx[XW-1:0]};
      end
    end
  end

  // truncate toward zero of value / 2^31
  function automatic logic signed [12:0] trunc31(input logic signed [43:0] v);
    logic signed [43:0] t;
    t = v[43] ? v + 44'sh7FFFFFFF : v;
    return t[43:31];
  endfunction

  awcb_div u_div (.clk(clk), .rst(rst), .go(dgo), .num(sum[ch]), .den(n),
                  .done(ddone), .quo(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      dgo    <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      dgo    <= 1'b0;
      pend   <= rd_en;
      unique case (state)
        S_IDLE: if (start && req.req_type) begin
          rq    <= req;
          state <= S_M1;
        end
        S_M1: begin
          px <= 25'(($signed({1'b0, rq.pos_x}) * 2 - FrameWidth) * $signed({1'b0, cfg.inv_scale}));
          py <= 25'(($signed({1'b0, rq.pos_y}) * 2 - FrameHeight) * $signed({1'b0, cfg.inv_scale}));
          state <= S_M2;
        end
        S_M2: begin
          pxc <= px * cfg.rot_cos;
          pys <= py * cfg.rot_sin;
          pxs <= px * cfg.rot_sin;
          pyc <= py * cfg.rot_cos;
          state <= S_M3;
        end
        S_M3: begin
          bx <= trunc31(sx);
          by <= trunc31(sy);
          rad <= rad_sat;
          off <= -$signed({2'b0, rad_sat});
          phase <= 1'b0;
          n <= '0;
          for (int k = 0; k < 4; k++) sum[k] <= '0;
          state <= S_SAMP;
        end
        S_SAMP: begin
          if (bx < 0 || bx >= FrameWidth || by < 0 || by >= FrameHeight) begin
            border <= 1'b1;
            state  <= S_OUT;
          end else begin
            border <= 1'b0;
            phase <= !phase;
            if (phase) begin
              if (off + 7'sd2 > $signed({2'b0, rad})) state <= S_LAST;
              off <= off + 7'sd2;
            end
          end
          if (pend) begin
            for (int k = 0; k < 4; k++) sum[k] <= sum[k] + 14'(rdata[8*k +: 8]);
            n <= n + 6'd1;
          end
        end
        S_LAST: begin
          if (pend) begin
            for (int k = 0; k < 4; k++) sum[k] <= sum[k] + 14'(rdata[8*k +: 8]);
            n <= n + 6'd1;
          end
          ch <= 2'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (n == 6'd0) n <= 6'd1;
          dgo   <= 1'b1;
          state <= S_WAITD;
        end
        S_WAITD: if (ddone) begin
          avg[ch] <= dq;
          if (ch == 2'd3) state <= S_OUT;
          else begin
            ch  <= ch + 2'd1;
            dgo <= 1'b1;
          end
        end
        S_OUT: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (border) begin
      res.out_red   = cfg.back_rgb[7:0];
      res.out_green = cfg.back_rgb[15:8];
      res.out_blue  = cfg.back_rgb[23:16];
      res.out_alpha = scale_alpha(8'd255, cfg.opacity);
    end else begin
      res.out_red   = avg[0];
      res.out_green = avg[1];
      res.out_blue  = avg[2];
      res.out_alpha = scale_alpha(avg[3], cfg.opacity);
    end
    res.out_border = border;
  end

`ifndef NO_ASSERTIONS
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_IDLE) else $error("load while busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> state == S_IDLE) else $error("strobe outside idle");
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> n <= 6'(2*MaxBlur+1)) else $error("sample count overflow");
`endif
endmodule

// File: sv/affine_warp_cross_blur.sv
// Top level of the affine warp with cross blur: register file plus render core.
// Depends on awcb_pkg, awcb_regs, awcb_core.
//  channel | handshake           | payload
//  request | start / busy        | req (req_t)
//  result  | strobe, one cycle   | res (res_t)
//  config  | APB psel/penable    | paddr, pwdata, prdata
// A load is written in the cycle start is taken and never raises busy. A render
// holds busy through warp states S_M1, S_M2, S_M3, then decides the border; a
// border pixel goes straight to S_OUT. Otherwise the sweep visits the horizontal,
// then the vertical sample of each offset from -radius to +radius in steps of 2,
// closes in S_LAST and sends the four sums in turn through the shared bit-serial
// divider; S_OUT then strobes the result as busy falls, when start is taken again.
// Reset is synchronous; the frame store is not cleared. Results cannot be stalled.
module affine_warp_cross_blur import awcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        strobe,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t cfg;

  awcb_regs u_regs (.clk(clk), .rst(rst), .psel(psel), .penable(penable),
                    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
                    .prdata(prdata), .pready(pready), .cfg(cfg));

  awcb_core u_core (.clk(clk), .rst(rst), .start(start), .req(req), .cfg(cfg),
                    .busy(busy), .strobe(strobe), .res(res));
endmodule
